// ===== src/zsa_pkg.sv =====
package zsa_pkg;

  // Fixed field widths
  localparam int KIND_W   = 3;
  localparam int SPOT_W   = 6;
  localparam int ZONE_W   = 8;
  localparam int OWNER_W  = 32;
  localparam int STATUS_W = 3;

  // Owner value of a spot that has none
  localparam logic [OWNER_W-1:0] NO_OWNER = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_ASSIGN = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_UNDO   = 3'd3,
    KIND_LIST   = 3'd4,
    KIND_QUERY  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_UNKNOWN    = 3'd1,
    STAT_OCCUPIED   = 3'd2,
    STAT_NONE_FREE  = 3'd3,
    STAT_LIST_FULL  = 3'd4,
    STAT_UNDO_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_OWN,
    FSM_UNDO,
    FSM_SCAN,
    FSM_EMIT
  } fsm_t;

  // Zone list entry: zone above spot
  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [SPOT_W-1:0] spot;
  } list_entry_t;

  // Undo record: spot, previous busy flag, previous owner
  typedef struct packed {
    logic [SPOT_W-1:0]  spot;
    logic               busy;
    logic [OWNER_W-1:0] owner;
  } undo_rec_t;

  // One result word
  typedef struct packed {
    status_t            status;
    logic [SPOT_W-1:0]  spot;
    logic               busy;
    logic [OWNER_W-1:0] owner;
    logic               last;
  } rsp_word_t;

endpackage

// ===== src/zsa_in_if.sv =====
interface zsa_in_if;
  logic                                valid;
  logic                                ready;
  logic [zsa_pkg::KIND_W-1:0]          kind;
  logic [zsa_pkg::SPOT_W-1:0]          spot_index;
  logic [zsa_pkg::ZONE_W-1:0]          zone;
  logic signed [zsa_pkg::OWNER_W-1:0]  vehicle_id;

  modport source (output valid, kind, spot_index, zone, vehicle_id, input ready);
  modport sink (input valid, kind, spot_index, zone, vehicle_id, output ready);
endinterface

// ===== src/zsa_out_if.sv =====
interface zsa_out_if;
  logic                                valid;
  logic                                ready;
  logic [zsa_pkg::STATUS_W-1:0]        status;
  logic [zsa_pkg::SPOT_W-1:0]          result_spot;
  logic                                spot_busy;
  logic signed [zsa_pkg::OWNER_W-1:0]  owner_id;
  logic                                last;

  modport source (output valid, status, result_spot, spot_busy, owner_id, last, input ready);
  modport sink (input valid, status, result_spot, spot_busy, owner_id, last, output ready);
endinterface

// ===== src/zsa_ram.sv =====
module zsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/zoned_slot_allocator_undo.sv =====
// Slot allocator with zones and an undo ring. Each word on req carries one
// operation (add spot, assign owner, find first free spot of a zone, undo the
// last assign, list free spots of a zone, query a spot); each produces one
// word on rsp, except list, which gives one word per free spot with last set
// on the final one, and kinds 6 and 7, which give none. One operation is in
// work at a time and req is ready only between operations; a finished word
// waits in an output register, so req can be taken while it is unread.
// Assign, query and undo make one owner or undo memory read each; find and
// list scan the zone list entry by entry, up to LIST_DEPTH entries; any
// operation also waits while rsp holds ready low. The scan reads the zone
// list memory one entry per cycle, except while a list word waits for rsp
// ready. Spot flags reset at once; owner, zone list and undo memories need
// no clearing pass.
module zoned_slot_allocator_undo #(
  parameter int SPOT_COUNT = 64,
  parameter int LIST_DEPTH = 64,
  parameter int UNDO_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  zsa_in_if.sink     req,
  zsa_out_if.source  rsp
);

  localparam int SA  = $clog2(SPOT_COUNT);
  localparam int LA  = $clog2(LIST_DEPTH);
  localparam int LCW = $clog2(LIST_DEPTH + 1);
  localparam int UA  = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
  localparam int UCW = $clog2(UNDO_DEPTH + 1);
  localparam int LW  = $bits(zsa_pkg::list_entry_t);
  localparam int RW  = $bits(zsa_pkg::undo_rec_t);
  localparam logic [zsa_pkg::SPOT_W:0] SPOT_LIM = (zsa_pkg::SPOT_W + 1)'(SPOT_COUNT);

  // Control state
  zsa_pkg::fsm_t           state, state_next;
  logic [SPOT_COUNT-1:0]   defined;
  logic [SPOT_COUNT-1:0]   occupied;
  logic [LCW-1:0]          list_count;
  logic [UA-1:0]           undo_top;
  logic [UCW-1:0]          undo_count;
  logic                    out_valid;
  logic                    found;
  logic [LA-1:0]           idx;

  // Payload registers
  logic [zsa_pkg::KIND_W-1:0]  kind_q;
  logic [zsa_pkg::SPOT_W-1:0]  spot_q;
  logic [zsa_pkg::ZONE_W-1:0]  zone_q;
  logic [zsa_pkg::OWNER_W-1:0] vid_q;
  logic [zsa_pkg::SPOT_W-1:0]  pend;
  zsa_pkg::rsp_word_t          res, res_d;
  zsa_pkg::rsp_word_t          out_q, out_d;
  logic                        res_load, out_load;

  // Memory ports
  logic                        own_we;
  logic [SA-1:0]               own_waddr, own_raddr;
  logic [zsa_pkg::OWNER_W-1:0] own_wdata, own_rdata;
  logic                        list_we;
  logic [LA-1:0]               list_raddr;
  zsa_pkg::list_entry_t        list_wdata, entry;
  logic [LW-1:0]               list_rdata;
  logic                        undo_we;
  logic [UA-1:0]               undo_raddr;
  zsa_pkg::undo_rec_t          undo_wdata, rec;
  logic [RW-1:0]               undo_rdata;

  zsa_ram #(.WIDTH(zsa_pkg::OWNER_W), .DEPTH(SPOT_COUNT)) u_owner_ram (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata)
  );

  zsa_ram #(.WIDTH(LW), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_count[LA-1:0]), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata)
  );

  zsa_ram #(.WIDTH(RW), .DEPTH(UNDO_DEPTH)) u_undo_ram (
    .clk(clk), .we(undo_we), .waddr(undo_top), .wdata(undo_wdata),
    .raddr(undo_raddr), .rdata(undo_rdata)
  );

  assign entry = zsa_pkg::list_entry_t'(list_rdata);
  assign rec   = zsa_pkg::undo_rec_t'(undo_rdata);

  // Addressed spot checks
  logic          s_ok, s_known, s_busy;
  logic [SA-1:0] s_a;
  assign s_ok    = {1'b0, spot_q} < SPOT_LIM;
  assign s_a     = spot_q[SA-1:0];
  assign s_known = s_ok && defined[s_a];
  assign s_busy  = s_ok && occupied[s_a];

  // Scan checks on the entry read last cycle
  logic          e_ok, match, last_entry, out_free;
  logic          scan_emit, scan_stall, scan_done, advance;
  logic [SA-1:0] e_a, r_a;
  assign e_a        = entry.spot[SA-1:0];
  assign e_ok       = {1'b0, entry.spot} < SPOT_LIM;
  assign match      = (entry.zone == zone_q) && e_ok && defined[e_a] && !occupied[e_a];
  assign last_entry = (LCW'(idx) + LCW'(1)) == list_count;
  assign out_free   = !out_valid || rsp.ready;
  assign scan_emit  = (kind_q == zsa_pkg::KIND_LIST) && match && found;
  assign scan_stall = scan_emit && !out_free;
  assign scan_done  = !scan_stall &&
                      (((kind_q == zsa_pkg::KIND_FIND) && match) || last_entry);
  assign advance    = !scan_stall && !scan_done;
  assign r_a        = rec.spot[SA-1:0];

  // Undo ring pointers
  logic [UA-1:0] top_inc, top_dec;
  assign top_inc = (undo_top == UA'(UNDO_DEPTH - 1)) ? '0 : undo_top + UA'(1);
  assign top_dec = (undo_top == '0) ? UA'(UNDO_DEPTH - 1) : undo_top - UA'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      zsa_pkg::FSM_IDLE: begin
        if (req.valid) state_next = zsa_pkg::FSM_EXEC;
      end
      zsa_pkg::FSM_EXEC: begin
        case (kind_q)
          zsa_pkg::KIND_ADD:    state_next = zsa_pkg::FSM_EMIT;
          zsa_pkg::KIND_ASSIGN,
          zsa_pkg::KIND_QUERY:  state_next = s_known ? zsa_pkg::FSM_OWN : zsa_pkg::FSM_EMIT;
          zsa_pkg::KIND_UNDO:   state_next = (undo_count != '0) ? zsa_pkg::FSM_UNDO
                                                                : zsa_pkg::FSM_EMIT;
          zsa_pkg::KIND_FIND,
          zsa_pkg::KIND_LIST:   state_next = (list_count != '0) ? zsa_pkg::FSM_SCAN
                                                                : zsa_pkg::FSM_EMIT;
          default:              state_next = zsa_pkg::FSM_IDLE;
        endcase
      end
      zsa_pkg::FSM_OWN:  state_next = zsa_pkg::FSM_EMIT;
      zsa_pkg::FSM_UNDO: state_next = zsa_pkg::FSM_EMIT;
      zsa_pkg::FSM_SCAN: begin
        if (scan_done) state_next = zsa_pkg::FSM_EMIT;
      end
      zsa_pkg::FSM_EMIT: begin
        if (out_free) state_next = zsa_pkg::FSM_IDLE;
      end
      default: state_next = zsa_pkg::FSM_IDLE;
    endcase
  end

  // Memory controls and result words
  always_comb begin
    own_we     = 1'b0;
    own_waddr  = s_a;
    own_wdata  = vid_q;
    own_raddr  = s_a;
    list_we    = 1'b0;
    list_wdata = '{zone: zone_q, spot: spot_q};
    list_raddr = '0;
    undo_we    = 1'b0;
    undo_wdata = '{spot: spot_q, busy: 1'b0, owner: own_rdata};
    undo_raddr = top_dec;
    res_load   = 1'b0;
    res_d      = '{status: zsa_pkg::STAT_UNKNOWN, spot: spot_q, busy: 1'b0,
                   owner: zsa_pkg::NO_OWNER, last: 1'b1};
    out_load   = 1'b0;
    out_d      = res;
    case (state)
      zsa_pkg::FSM_EXEC: begin
        case (kind_q)
          zsa_pkg::KIND_ADD: begin
            res_load = 1'b1;
            if (!s_ok) begin
              res_d.status = zsa_pkg::STAT_UNKNOWN;
            end else if (list_count == LCW'(LIST_DEPTH)) begin
              res_d.status = zsa_pkg::STAT_LIST_FULL;
            end else begin
              res_d.status = zsa_pkg::STAT_OK;
              own_we       = 1'b1;
              own_wdata    = zsa_pkg::NO_OWNER;
              list_we      = 1'b1;
            end
          end
          zsa_pkg::KIND_ASSIGN,
          zsa_pkg::KIND_QUERY: begin
            res_load = !s_known;
          end
          zsa_pkg::KIND_UNDO: begin
            res_load     = (undo_count == '0);
            res_d.status = zsa_pkg::STAT_UNDO_EMPTY;
            res_d.spot   = '0;
          end
          zsa_pkg::KIND_FIND,
          zsa_pkg::KIND_LIST: begin
            res_load     = (list_count == '0);
            res_d.status = zsa_pkg::STAT_NONE_FREE;
            res_d.spot   = '0;
          end
          default: ;
        endcase
      end
      zsa_pkg::FSM_OWN: begin
        res_load = 1'b1;
        if (kind_q == zsa_pkg::KIND_QUERY) begin
          res_d = '{status: zsa_pkg::STAT_OK, spot: spot_q, busy: s_busy,
                    owner: own_rdata, last: 1'b1};
        end else if (s_busy) begin
          res_d = '{status: zsa_pkg::STAT_OCCUPIED, spot: spot_q, busy: 1'b1,
                    owner: own_rdata, last: 1'b1};
        end else begin
          undo_we = 1'b1;
          own_we  = 1'b1;
          res_d   = '{status: zsa_pkg::STAT_OK, spot: spot_q, busy: 1'b1,
                      owner: vid_q, last: 1'b1};
        end
      end
      zsa_pkg::FSM_UNDO: begin
        own_we    = 1'b1;
        own_waddr = r_a;
        own_wdata = rec.owner;
        res_load  = 1'b1;
        res_d     = '{status: zsa_pkg::STAT_OK, spot: rec.spot, busy: rec.busy,
                      owner: rec.owner, last: 1'b1};
      end
      zsa_pkg::FSM_SCAN: begin
        // Re-read the same entry while stalled
        list_raddr = advance ? idx + LA'(1) : idx;
        // A free spot always has no owner: add clears it, undo restores a free one
        if (scan_emit && out_free) begin
          out_load = 1'b1;
          out_d    = '{status: zsa_pkg::STAT_OK, spot: pend, busy: 1'b0,
                       owner: zsa_pkg::NO_OWNER, last: 1'b0};
        end
        if (scan_done) begin
          res_load = 1'b1;
          if (match || found) begin
            res_d.status = zsa_pkg::STAT_OK;
            res_d.spot   = match ? entry.spot : pend;
          end else begin
            res_d.status = zsa_pkg::STAT_NONE_FREE;
            res_d.spot   = '0;
          end
        end
      end
      zsa_pkg::FSM_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= zsa_pkg::FSM_IDLE;
      defined    <= '0;
      occupied   <= '0;
      list_count <= '0;
      undo_top   <= '0;
      undo_count <= '0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        zsa_pkg::FSM_EXEC: begin
          if (kind_q == zsa_pkg::KIND_ADD && list_we) begin
            defined[s_a]  <= 1'b1;
            occupied[s_a] <= 1'b0;
            list_count    <= list_count + LCW'(1);
          end
          if (kind_q == zsa_pkg::KIND_UNDO && undo_count != '0) begin
            undo_top   <= top_dec;
            undo_count <= undo_count - UCW'(1);
          end
          idx   <= '0;
          found <= 1'b0;
        end
        zsa_pkg::FSM_OWN: begin
          if (undo_we) begin
            occupied[s_a] <= 1'b1;
            undo_top      <= top_inc;
            if (undo_count != UCW'(UNDO_DEPTH)) undo_count <= undo_count + UCW'(1);
          end
        end
        zsa_pkg::FSM_UNDO: begin
          occupied[r_a] <= rec.busy;
        end
        zsa_pkg::FSM_SCAN: begin
          if (!scan_stall && match) found <= 1'b1;
          if (advance) idx <= idx + LA'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == zsa_pkg::FSM_IDLE && req.valid) begin
      kind_q <= req.kind;
      spot_q <= req.spot_index;
      zone_q <= req.zone;
      vid_q  <= req.vehicle_id;
    end
    if (state == zsa_pkg::FSM_SCAN && !scan_stall && match) pend <= entry.spot;
    if (res_load) res <= res_d;
    if (out_load) out_q <= out_d;
  end

  assign req.ready       = (state == zsa_pkg::FSM_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_q.status;
  assign rsp.result_spot = out_q.spot;
  assign rsp.spot_busy   = out_q.busy;
  assign rsp.owner_id    = out_q.owner;
  assign rsp.last        = out_q.last;

  // Checks
  a_undo_bound: assert property (@(posedge clk) disable iff (rst)
    undo_count <= UCW'(UNDO_DEPTH))
    else $error("undo count beyond ring depth");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    list_count <= LCW'(LIST_DEPTH))
    else $error("zone list count beyond depth");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    state == zsa_pkg::FSM_SCAN |-> LCW'(idx) < list_count)
    else $error("scan index past zone list end");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == zsa_pkg::FSM_EXEC)
    else $error("accepted word not executed");

  a_assign_sets: assert property (@(posedge clk) disable iff (rst)
    state == zsa_pkg::FSM_OWN && undo_we |=> occupied[$past(s_a)])
    else $error("assign did not mark spot occupied");

endmodule
